### rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg: shared types and constants for the biphase pulse decoder
// Request codes, register indexes, capture capacity and the capture state.
// ----------------------------------------------------------------------------
package bpd_pkg;

  // Capture capacity in bytes (1 to 256); the byte counter is 9 bits wide.
  localparam int unsigned CAPACITY_BYTES = 256;
  localparam logic [8:0]  CAP_BYTES      = 9'(CAPACITY_BYTES);
  localparam logic [7:0]  CAP_LAST_IDX   = 8'(CAPACITY_BYTES - 1);

  localparam int unsigned PW_W   = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 8;

  // Reset values of the registers
  localparam logic [7:0] HALF_BIT_RST = 8'd16;
  localparam logic       INVERT_RST   = 1'b0;

  // Register indexes on the write port
  localparam logic CFG_HALF_BIT = 1'b0;
  localparam logic CFG_INVERT   = 1'b1;

  // Request codes; the fourth code means nothing and is ignored
  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_PULSE  = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  typedef struct packed {
    logic       active;
    logic       half_seen;
    logic       in_error_run;
    logic [7:0] byte_acc;
    logic [7:0] invalid_acc;
    logic [2:0] bit_count;
    logic [8:0] byte_count;
  } cap_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data_byte;
    logic [7:0] invalid_mask;
    logic [7:0] byte_index;
    logic       capture_full;
  } byte_out_t;

  typedef struct packed {
    cap_state_t st;
    byte_out_t  res;
  } pack_res_t;

  localparam cap_state_t CAP_CLEAR = '{
    active:       1'b0,
    half_seen:    1'b0,
    in_error_run: 1'b0,
    byte_acc:     8'h00,
    invalid_acc:  8'hFF,
    bit_count:    3'd0,
    byte_count:   9'd0
  };

endpackage

### rtl/biphase_pulse_decoder_top.sv
// ----------------------------------------------------------------------------
// biphase_pulse_decoder_top: biphase pulse-width decoder
// Classes pulse widths as long, short-half or out of range and packs bytes.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one request per accepted cycle.
//   in_req_type selects start capture, one measured pulse (in_pulse_width in
//   timer counts) or finish capture. The unused code is dropped.
//   Result channel (out_valid / out_stall): one completed byte with its
//   invalid mask, byte position and capacity flag. A request yields zero
//   or one byte.
//   Path: an accepted request is stored in the input register, decoded and
//   packed, and its byte is stored in the result register. Throughput: one
//   request per cycle unless a stalled byte holds the result register, set by
//   the single decode/pack pass between the two registers.
//   Stall: while a byte waits under out_stall, one more request is held in
//   the input register; in_stall rises only when both are full.
//   Reset (rst_n low, synchronous): capture inactive, pipeline empty,
//   half_bit_period = 16, invert_bits = 0.
//   Configuration: write cfg_wdata to register cfg_index on cfg_wr_en, only
//   while no request is in flight.
// ----------------------------------------------------------------------------
module biphase_pulse_decoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [bpd_pkg::PW_W-1:0]   in_pulse_width,
  // byte channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bpd_pkg::BYTE_W-1:0] out_data_byte,
  output logic [bpd_pkg::BYTE_W-1:0] out_invalid_mask,
  output logic [bpd_pkg::BYTE_W-1:0] out_byte_index,
  output logic                       out_capture_full,
  // register writes
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [bpd_pkg::CFG_W-1:0]  cfg_wdata
);
  import bpd_pkg::*;

  // Pack one bit into the current byte; emit the byte when it completes.
  function automatic pack_res_t pack_bit(cap_state_t s, logic bit_in, logic vld,
                                         logic inv);
    pack_res_t  r;
    logic       b;
    logic [7:0] pos;
    logic [8:0] cnt;
    r     = '{st: s, res: '0};
    b     = bit_in ^ inv;
    pos   = 8'h80 >> s.bit_count;
    cnt   = s.byte_count + 9'd1;
    if (s.active) begin
      if (b) begin
        r.st.byte_acc = s.byte_acc | pos;
      end
      if (vld) begin
        r.st.invalid_acc = s.invalid_acc & ~pos;
      end
      if (s.bit_count == 3'd7) begin
        r.res.emit         = 1'b1;
        r.res.data_byte    = r.st.byte_acc;
        r.res.invalid_mask = r.st.invalid_acc;
        r.res.byte_index   = s.byte_count[7:0];
        r.res.capture_full = (cnt >= CAP_BYTES);
        r.st.byte_count    = cnt;
        r.st.bit_count     = 3'd0;
        r.st.byte_acc      = 8'h00;
        r.st.invalid_acc   = 8'hFF;
        if (cnt >= CAP_BYTES) begin
          r.st.active = 1'b0;
        end
      end else begin
        r.st.bit_count = s.bit_count + 3'd1;
      end
    end
    return r;
  endfunction

  // Configuration registers
  logic [7:0] half_bit_r;
  logic       invert_r;

  // Input register
  logic              s1_valid_r;
  req_t              s1_req_r;
  logic [PW_W-1:0]   s1_width_r;

  // Capture state
  cap_state_t st_r, st_nxt;

  // Result register
  logic      out_valid_r;
  byte_out_t out_r, res_nxt;

  logic       proc_en;

  // Pulse classification, all in wrapping 8-bit arithmetic
  logic [7:0] width_clamp;
  logic [7:0] adj;
  logic [7:0] adj2;
  logic       long_pulse;
  logic       out_of_range;

  pack_res_t  pk_a, pk_b, pk_c, pk_pad;
  cap_state_t pad_st;
  logic [7:0] pad_fill;

  // A request moves into the decode pass unless the result slot is held.
  assign proc_en  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= HALF_BIT_RST;
      invert_r   <= INVERT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HALF_BIT: half_bit_r <= cfg_wdata;
        CFG_INVERT:   invert_r   <= cfg_wdata[0];
        default:      half_bit_r <= half_bit_r;
      endcase
    end
  end

  // Input register: load on accept, drain when the decode pass takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (proc_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r   <= req_t'(in_req_type);
      s1_width_r <= in_pulse_width;
    end
  end

  // Clamp to 255, add the tolerance, subtract one half period; a result above
  // the half period marks a long pulse and is reduced by a second subtract.
  // Anything still above the half period is out of range.
  always_comb begin
    width_clamp  = (|s1_width_r[PW_W-1:8]) ? 8'hFF : s1_width_r[7:0];
    adj          = width_clamp + {1'b0, half_bit_r[7:1]} - half_bit_r;
    long_pulse   = (adj > half_bit_r);
    adj2         = long_pulse ? (adj - half_bit_r) : adj;
    out_of_range = (adj2 > half_bit_r);
  end

  // Decode and pack one request
  always_comb begin
    st_nxt   = st_r;
    res_nxt  = '0;
    pk_a     = pack_bit(st_r, ~st_r.half_seen, 1'b1, invert_r);
    pk_b     = pack_bit(pk_a.st, 1'b0, 1'b0, invert_r);
    pk_c     = pack_bit(st_r, long_pulse, 1'b1, invert_r);
    // Padding: fill the open positions with the inverted zero, then let the
    // last position close the byte.
    pad_st   = st_r.in_error_run ? st_r : pk_a.st;
    pad_fill = (8'hFF >> pad_st.bit_count) & 8'hFE;
    if (invert_r) begin
      pad_st.byte_acc = pad_st.byte_acc | pad_fill;
    end
    pad_st.bit_count = 3'd7;
    pk_pad   = pack_bit(pad_st, 1'b0, 1'b0, invert_r);

    unique case (s1_req_r)
      REQ_START: begin
        st_nxt        = CAP_CLEAR;
        st_nxt.active = 1'b1;
      end
      REQ_PULSE: begin
        if (st_r.active) begin
          priority if (out_of_range) begin
            if (!st_r.in_error_run) begin
              st_nxt              = pk_b.st;
              res_nxt             = pk_a.res.emit ? pk_a.res : pk_b.res;
              st_nxt.in_error_run = 1'b1;
            end
            st_nxt.half_seen = 1'b0;
          end else if (long_pulse || st_r.half_seen) begin
            // long pulse is a one, second short half completes a zero
            st_nxt              = pk_c.st;
            res_nxt             = pk_c.res;
            st_nxt.half_seen    = 1'b0;
            st_nxt.in_error_run = 1'b0;
          end else begin
            st_nxt.half_seen = 1'b1;
          end
        end
      end
      REQ_FINISH: begin
        if (st_r.active) begin
          priority if (!st_r.in_error_run && pk_a.res.emit) begin
            st_nxt  = pk_a.st;
            res_nxt = pk_a.res;
          end else if (pad_st.active && (st_r.in_error_run ? st_r.bit_count
                                                           : pk_a.st.bit_count) != 3'd0) begin
            st_nxt  = pk_pad.st;
            res_nxt = pk_pad.res;
          end else begin
            st_nxt = st_r.in_error_run ? st_r : pk_a.st;
          end
        end
        st_nxt.active = 1'b0;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CAP_CLEAR;
    end else if (proc_en) begin
      st_r <= st_nxt;
    end
  end

  // Result register: replace on a decode pass, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en) begin
      out_valid_r <= res_nxt.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && res_nxt.emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_r.data_byte;
  assign out_invalid_mask = out_r.invalid_mask;
  assign out_byte_index   = out_r.byte_index;
  assign out_capture_full = out_r.capture_full;

endmodule

### rtl/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_checker: port-level checks for the biphase pulse decoder
// Watches the request and byte channels of the top level over time.
// ----------------------------------------------------------------------------
module bpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_invalid_mask,
  input logic [7:0] out_byte_index,
  input logic       out_capture_full
);
  import bpd_pkg::*;

  // Reset leaves the byte channel empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("byte shown right after reset");

  // A stalled byte holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_invalid_mask) && $stable(out_byte_index) &&
      $stable(out_capture_full))
    else $error("stalled byte changed");

  // A fresh byte needs an accepted request that went through the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("byte without a request");

  // Request side stalls only while a byte is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with free result slot");

  // Capacity is reached only on the last byte position
  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_capture_full |-> out_byte_index == CAP_LAST_IDX)
    else $error("capacity flag on wrong byte");

endmodule

bind biphase_pulse_decoder_top bpd_checker u_bpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_data_byte    (out_data_byte),
  .out_invalid_mask (out_invalid_mask),
  .out_byte_index   (out_byte_index),
  .out_capture_full (out_capture_full)
);
